// File: rtl/adcth_pkg.sv
`timescale 1ns / 1ps

package adcth_pkg;

   localparam int SAMPLE_W           = 10;
   localparam int TEMP_W             = 12;
   localparam int CORR_W             = 8;
   localparam int AVERAGING_BITS_DEF = 4;
   localparam int TABLE_ENTRIES_DEF  = 165;
   localparam int ROM_DEPTH          = 165;
   localparam int ROM_ADDR_W         = 8;
   localparam int ROM_IDX_W          = 9;
   localparam int TENTHS_PER_DEG     = 10;
   localparam int BASE_TENTHS        = -520;
   localparam int NUM_W              = SAMPLE_W + 4;
   localparam int Q_W                = 4;
   localparam int CNT_W              = 2;
   localparam int DIV_STEPS          = 4;

   localparam logic [SAMPLE_W-1:0] THERM_ROM [ROM_DEPTH] = '{
      10'd974, 10'd971, 10'd967, 10'd964, 10'd960, 10'd956, 10'd953, 10'd948, 10'd944, 10'd940,
      10'd935, 10'd930, 10'd925, 10'd920, 10'd914, 10'd909, 10'd903, 10'd897, 10'd891, 10'd884,
      10'd877, 10'd871, 10'd864, 10'd856, 10'd849, 10'd841, 10'd833, 10'd825, 10'd817, 10'd809,
      10'd800, 10'd791, 10'd782, 10'd773, 10'd764, 10'd754, 10'd745, 10'd735, 10'd725, 10'd715,
      10'd705, 10'd695, 10'd685, 10'd675, 10'd664, 10'd654, 10'd644, 10'd633, 10'd623, 10'd612,
      10'd601, 10'd591, 10'd580, 10'd570, 10'd559, 10'd549, 10'd538, 10'd528, 10'd518, 10'd507,
      10'd497, 10'd487, 10'd477, 10'd467, 10'd457, 10'd448, 10'd438, 10'd429, 10'd419, 10'd410,
      10'd401, 10'd392, 10'd383, 10'd375, 10'd366, 10'd358, 10'd349, 10'd341, 10'd333, 10'd326,
      10'd318, 10'd310, 10'd303, 10'd296, 10'd289, 10'd282, 10'd275, 10'd269, 10'd262, 10'd256,
      10'd250, 10'd244, 10'd238, 10'd232, 10'd226, 10'd221, 10'd215, 10'd210, 10'd205, 10'd200,
      10'd195, 10'd191, 10'd186, 10'd181, 10'd177, 10'd173, 10'd169, 10'd165, 10'd161, 10'd157,
      10'd153, 10'd149, 10'd146, 10'd142, 10'd139, 10'd136, 10'd132, 10'd129, 10'd126, 10'd123,
      10'd120, 10'd117, 10'd115, 10'd112, 10'd109, 10'd107, 10'd104, 10'd102, 10'd100, 10'd97,
      10'd95,  10'd93,  10'd91,  10'd89,  10'd87,  10'd85,  10'd83,  10'd81,  10'd79,  10'd78,
      10'd76,  10'd74,  10'd73,  10'd71,  10'd69,  10'd68,  10'd67,  10'd65,  10'd64,  10'd62,
      10'd61,  10'd60,  10'd58,  10'd57,  10'd56,  10'd55,  10'd54,  10'd53,  10'd52,  10'd51,
      10'd49,  10'd48,  10'd47,  10'd47,  10'd46
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG,
      ST_SEARCH,
      ST_LOOKUP,
      ST_DIVIDE,
      ST_FINAL,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load;
      logic avg;
      logic search_step;
      logic lookup;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic search_done;
      logic needs_div;
      logic div_last;
   } status_type;

   function automatic logic [SAMPLE_W-1:0] adcth_rom(input logic [ROM_IDX_W-1:0] idx);
      logic [SAMPLE_W-1:0] val;
      val = '0;
      if (idx < ROM_IDX_W'(ROM_DEPTH)) begin
         val = THERM_ROM[idx[ROM_ADDR_W-1:0]];
      end
      return val;
   endfunction

endpackage

// File: rtl/adc_average_thermistor_convert.sv
`timescale 1ns / 1ps

// Averaging thermistor converter.
// Input: req_valid/req_ready carry one ADC sample (req_adc_sample) per transfer.
// Output: rsp_valid/rsp_ready carry one result per sample: the sample echoed,
// the averaged level, the temperature in tenths of a degree and the
// below_table flag set when the level falls under the last table entry.
// csr_wr_en/csr_wr_data write the signed temperature correction; write it
// only while no sample is in flight.
// Flow: the accepted sample is averaged, the table is searched, the interval
// is looked up, divided when the level needs interpolation, and finished
// with the correction before rsp_valid rises. The binary search probes one table
// entry per cycle (7 or 8 probes for a 165-entry table), the divider resolves
// one quotient bit per cycle for a 4-bit quotient. One sample is processed at a
// time: no new sample is taken until the result has been transferred.
// Reset clears the average accumulator and the correction; the block comes
// up idle with req_ready high.
// While rsp_ready is low the result holds and req_ready stays low.

module adc_average_thermistor_convert
   import adcth_pkg::*;
#(
   parameter int AVERAGING_BITS = AVERAGING_BITS_DEF,
   parameter int TABLE_ENTRIES  = TABLE_ENTRIES_DEF
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [SAMPLE_W-1:0]       req_adc_sample,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SAMPLE_W-1:0]       rsp_raw_sample,
   output logic [SAMPLE_W-1:0]       rsp_averaged_level,
   output logic signed [TEMP_W-1:0]  rsp_temperature_tenths,
   output logic                      rsp_below_table,
   input  logic                      csr_wr_en,
   input  logic signed [CORR_W-1:0]  csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   adcth_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   adcth_datapath #(
      .AVERAGING_BITS (AVERAGING_BITS),
      .TABLE_ENTRIES  (TABLE_ENTRIES)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_adc_sample         (req_adc_sample),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .rsp_raw_sample         (rsp_raw_sample),
      .rsp_averaged_level     (rsp_averaged_level),
      .rsp_temperature_tenths (rsp_temperature_tenths),
      .rsp_below_table        (rsp_below_table)
   );

endmodule

// File: rtl/adcth_ctrl.sv
`timescale 1ns / 1ps

module adcth_ctrl
   import adcth_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_AVG;
         end
         ST_AVG: begin
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (status.search_done) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = status.needs_div ? ST_DIVIDE : ST_FINAL;
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      rsp_valid       = 1'b0;
      cmd             = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_AVG: begin
            cmd.avg = 1'b1;
         end
         ST_SEARCH: begin
            cmd.search_step = !status.search_done;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_FINAL: begin
            cmd.finish = 1'b1;
         end
         ST_RESULT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   a_load_starts_avg: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> cmd.avg)
      else $error("accepted sample not averaged next cycle");

   a_div_then_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step && status.div_last |=> cmd.finish)
      else $error("divider end not followed by finish");

endmodule

// File: rtl/adcth_datapath.sv
`timescale 1ns / 1ps

module adcth_datapath
   import adcth_pkg::*;
#(
   parameter int AVERAGING_BITS = AVERAGING_BITS_DEF,
   parameter int TABLE_ENTRIES  = TABLE_ENTRIES_DEF
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic [SAMPLE_W-1:0]       req_adc_sample,
   input  logic                      csr_wr_en,
   input  logic signed [CORR_W-1:0]  csr_wr_data,
   output logic [SAMPLE_W-1:0]       rsp_raw_sample,
   output logic [SAMPLE_W-1:0]       rsp_averaged_level,
   output logic signed [TEMP_W-1:0]  rsp_temperature_tenths,
   output logic                      rsp_below_table
);

   localparam int ACC_W = SAMPLE_W + AVERAGING_BITS;
   localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);

   logic [CORR_W-1:0]   corr_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic [ACC_W-1:0]    acc_in;
   logic [SAMPLE_W-1:0] level_ff;
   logic [IDX_W-1:0]    lo_ff;
   logic [IDX_W-1:0]    hi_ff;
   logic [IDX_W-1:0]    mid;
   logic [SAMPLE_W-1:0] rom_mid;
   logic [SAMPLE_W-1:0] rom_lo;
   logic [SAMPLE_W-1:0] rom_hi;
   logic [SAMPLE_W-1:0] span;
   logic [NUM_W-1:0]    num;
   logic [TEMP_W-1:0]   t_lo;
   logic                below;
   logic                needs_div;
   logic [NUM_W-1:0]    rem_ff;
   logic [SAMPLE_W-1:0] div_ff;
   logic [Q_W-1:0]      q_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [NUM_W-1:0]    trial;
   logic                take;
   logic                use_div_ff;
   logic [TEMP_W-1:0]   t_ff;
   logic [TEMP_W-1:0]   t_final;
   logic [TEMP_W-1:0]   temp_ff;
   logic                below_ff;

   always_comb begin
      if (acc_ff == '0) begin
         acc_in = {sample_ff, {AVERAGING_BITS{1'b0}}};
      end else begin
         acc_in = acc_ff + ACC_W'(sample_ff) - (acc_ff >> AVERAGING_BITS);
      end
   end

   assign mid     = IDX_W'((({1'b0, lo_ff} + {1'b0, hi_ff})) >> 1);
   assign rom_mid = adcth_rom(ROM_IDX_W'(mid));
   assign rom_lo  = adcth_rom(ROM_IDX_W'(lo_ff));
   assign rom_hi  = adcth_rom(ROM_IDX_W'(hi_ff));
   assign span    = rom_lo - rom_hi;
   assign num     = NUM_W'(level_ff - rom_hi) * NUM_W'(TENTHS_PER_DEG);
   assign t_lo    = TEMP_W'(lo_ff) * TEMP_W'(TENTHS_PER_DEG);

   always_comb begin
      below     = 1'b0;
      needs_div = 1'b0;
      if (level_ff >= rom_lo) begin
         below = 1'b0;
      end else if (hi_ff >= IDX_W'(TABLE_ENTRIES)) begin
         below = 1'b1;
      end else if (span == '0 || level_ff < rom_hi) begin
         needs_div = 1'b0;
      end else begin
         needs_div = 1'b1;
      end
   end

   assign trial = NUM_W'(div_ff) << cnt_ff;
   assign take  = rem_ff >= trial;

   assign t_final = use_div_ff
                  ? TEMP_W'(hi_ff) * TEMP_W'(TENTHS_PER_DEG) - TEMP_W'(q_ff)
                  : t_ff;

   assign status.search_done = IDX_W'(hi_ff - lo_ff) <= IDX_W'(1);
   assign status.needs_div   = needs_div;
   assign status.div_last    = cnt_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         corr_ff <= '0;
      end else if (csr_wr_en) begin
         corr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.avg) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_adc_sample;
      end
      if (cmd.avg) begin
         level_ff <= acc_in[ACC_W-1:AVERAGING_BITS];
         lo_ff    <= '0;
         hi_ff    <= IDX_W'(TABLE_ENTRIES);
      end
      if (cmd.search_step) begin
         if (level_ff > rom_mid) begin
            hi_ff <= mid;
         end else begin
            lo_ff <= mid;
         end
      end
      if (cmd.lookup) begin
         rem_ff     <= num;
         div_ff     <= span;
         q_ff       <= '0;
         cnt_ff     <= CNT_W'(DIV_STEPS - 1);
         use_div_ff <= needs_div;
         t_ff       <= t_lo;
         below_ff   <= below;
      end
      if (cmd.div_step) begin
         if (take) begin
            rem_ff <= rem_ff - trial;
         end
         q_ff   <= {q_ff[Q_W-2:0], take};
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
      if (cmd.finish) begin
         temp_ff <= t_final
                  + {{(TEMP_W - CORR_W){corr_ff[CORR_W-1]}}, corr_ff}
                  + TEMP_W'(BASE_TENTHS);
      end
   end

   assign rsp_raw_sample         = sample_ff;
   assign rsp_averaged_level     = level_ff;
   assign rsp_temperature_tenths = $signed(temp_ff);
   assign rsp_below_table        = below_ff;

   a_search_open: assert property (@(posedge clock) disable iff (reset)
      cmd.search_step |=> hi_ff > lo_ff)
      else $error("search interval collapsed");

   a_quotient_range: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && use_div_ff |-> q_ff <= Q_W'(TENTHS_PER_DEG - 1))
      else $error("interpolation step out of range");

endmodule
